/* src/functional_unit_reservation_defines.svh */
// ----------------------------------------------------------------------------
// Functional unit reservation: assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef FUNCTIONAL_UNIT_RESERVATION_DEFINES_SVH
`define FUNCTIONAL_UNIT_RESERVATION_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FUR_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> cons) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FUR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/fur_pkg.sv */
// ----------------------------------------------------------------------------
// Functional unit reservation package
// Widths, register indexes, reset values, item structures and helpers.
// ----------------------------------------------------------------------------
package fur_pkg;

    localparam int NUM_CLASSES_DEF = 8;
    localparam int UNITS_MAX_DEF   = 4;

    localparam int CYCLE_W        = 32;
    localparam int CLASS_W        = 3;
    localparam int LAT_W          = 8;
    localparam int CNT_W          = 32;
    localparam int UCNT_W         = 3;
    localparam int PACKED_CLASSES = 8;

    localparam int UNITS_REG_W = UCNT_W * PACKED_CLASSES;
    localparam int LAT_REG_W   = LAT_W * PACKED_CLASSES;
    localparam int CFG_DATA_W  = LAT_REG_W;
    localparam int CFG_ADDR_W  = 2;

    localparam int IN_FIELDS_W  = CLASS_W + 2 * CYCLE_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = LAT_W + CYCLE_W + 3 * CNT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [UNITS_REG_W-1:0] UNITS_RESET = '0;
    localparam logic [LAT_REG_W-1:0]   LAT_RESET   = 64'h0101_0101_0101_0101;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_UNITS     = 2'd0,
        CFG_ISSUE_LAT = 2'd1,
        CFG_OP_LAT    = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        KIND_RESERVE = 1'b0,
        KIND_RELEASE = 1'b1
    } kind_t;

    typedef struct packed {
        logic [UNITS_REG_W-1:0] units_per_class;
        logic [LAT_REG_W-1:0]   issue_latencies;
        logic [LAT_REG_W-1:0]   operation_latencies;
    } cfg_t;

    typedef struct packed {
        kind_t              kind;
        logic [CLASS_W-1:0] unit_class;
        logic [CYCLE_W-1:0] now_cycle;
        logic [CYCLE_W-1:0] first_try_cycle;
    } req_t;

    typedef struct packed {
        logic [LAT_W-1:0]   latency;
        logic [CYCLE_W-1:0] try_cycle_out;
        logic [CNT_W-1:0]   class_accesses;
        logic [CNT_W-1:0]   class_denials;
        logic [CNT_W-1:0]   class_wait_total;
    } rsp_t;

    // Unsigned add that sticks at the all-ones value on overflow.
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
    endfunction

endpackage

/* src/fur_table.sv */
// ----------------------------------------------------------------------------
// Functional unit reservation table
// Per-unit free cycles and per-class statistics, updated once per item.
// ----------------------------------------------------------------------------
module fur_table
    import fur_pkg::*;
#(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF,
    parameter int UNITS_MAX   = UNITS_MAX_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_fire,
    input  req_t req,
    input  cfg_t cfg,
    output rsp_t rsp
);

    localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

    // One lane per unit slot, each lane indexed by class.
    logic [CYCLE_W-1:0] free_at_reg [UNITS_MAX][NUM_CLASSES];
    logic [CNT_W-1:0]   grant_cnt_reg [NUM_CLASSES];
    logic [CNT_W-1:0]   deny_cnt_reg  [NUM_CLASSES];
    logic [CNT_W-1:0]   wait_sum_reg  [NUM_CLASSES];

    logic                 cls_ok;
    logic [CLS_W-1:0]     cls_idx;
    logic [UCNT_W-1:0]    units_raw;
    logic [UCNT_W-1:0]    units_n;
    logic [LAT_W-1:0]     issue_lat;
    logic [LAT_W-1:0]     op_lat;
    logic [CYCLE_W-1:0]   try_cyc;
    logic                 reserve;
    logic [UNITS_MAX-1:0] unit_free;
    logic [UNITS_MAX-1:0] grant_oh;
    logic                 granted;
    logic                 denied;
    logic [CNT_W-1:0]     grant_cnt_next;
    logic [CNT_W-1:0]     deny_cnt_next;
    logic [CNT_W-1:0]     wait_sum_next;
    logic [CYCLE_W-1:0]   busy_until;

    always_comb
    begin
        logic found;
        cls_ok    = int'(req.unit_class) < NUM_CLASSES;
        cls_idx   = CLS_W'(req.unit_class);
        units_raw = cfg.units_per_class[req.unit_class * UCNT_W +: UCNT_W];
        units_n   = (units_raw > UCNT_W'(UNITS_MAX)) ? UCNT_W'(UNITS_MAX) : units_raw;
        issue_lat = cfg.issue_latencies[req.unit_class * LAT_W +: LAT_W];
        op_lat    = cfg.operation_latencies[req.unit_class * LAT_W +: LAT_W];
        try_cyc   = (req.first_try_cycle == '0) ? req.now_cycle : req.first_try_cycle;
        reserve   = (req.kind == KIND_RESERVE) && (req.unit_class != '0) && cls_ok;

        // Lowest-numbered unit of the class that is free by now wins.
        found = 1'b0;
        for (int i = 0; i < UNITS_MAX; i++)
        begin
            unit_free[i] = reserve && (UCNT_W'(i) < units_n)
                           && (free_at_reg[i][cls_idx] <= req.now_cycle);
            grant_oh[i]  = unit_free[i] && !found;
            found        = found || unit_free[i];
        end
        granted = found;
        denied  = reserve && !found;

        busy_until     = req.now_cycle + CYCLE_W'(issue_lat);
        grant_cnt_next = sat_add(grant_cnt_reg[cls_idx], CNT_W'(1));
        deny_cnt_next  = sat_add(deny_cnt_reg[cls_idx], CNT_W'(1));
        wait_sum_next  = sat_add(wait_sum_reg[cls_idx], req.now_cycle - try_cyc);

        if (req.kind == KIND_RELEASE)
        begin
            rsp.latency       = '0;
            rsp.try_cycle_out = '0;
        end
        else if (req.unit_class == '0)
        begin
            rsp.latency       = LAT_W'(1);
            rsp.try_cycle_out = req.first_try_cycle;
        end
        else
        begin
            rsp.latency       = granted ? op_lat : '0;
            rsp.try_cycle_out = try_cyc;
        end

        if (cls_ok)
        begin
            rsp.class_accesses   = granted ? grant_cnt_next : grant_cnt_reg[cls_idx];
            rsp.class_denials    = denied ? deny_cnt_next : deny_cnt_reg[cls_idx];
            rsp.class_wait_total = granted ? wait_sum_next : wait_sum_reg[cls_idx];
        end
        else
        begin
            rsp.class_accesses   = '0;
            rsp.class_denials    = '0;
            rsp.class_wait_total = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                for (int i = 0; i < UNITS_MAX; i++)
                begin
                    free_at_reg[i][c] <= '0;
                end
                grant_cnt_reg[c] <= '0;
                deny_cnt_reg[c]  <= '0;
                wait_sum_reg[c]  <= '0;
            end
        end
        else if (req_fire)
        begin
            if (req.kind == KIND_RELEASE)
            begin
                for (int c = 0; c < NUM_CLASSES; c++)
                begin
                    for (int i = 0; i < UNITS_MAX; i++)
                    begin
                        free_at_reg[i][c] <= '0;
                    end
                end
            end
            else
            begin
                for (int i = 0; i < UNITS_MAX; i++)
                begin
                    if (grant_oh[i])
                    begin
                        free_at_reg[i][cls_idx] <= busy_until;
                    end
                end
                if (granted)
                begin
                    grant_cnt_reg[cls_idx] <= grant_cnt_next;
                    wait_sum_reg[cls_idx]  <= wait_sum_next;
                end
                if (denied)
                begin
                    deny_cnt_reg[cls_idx] <= deny_cnt_next;
                end
            end
        end
    end

endmodule

/* src/functional_unit_reservation.sv */
// Two registers (input, then result); a result is presented once its item has moved on
// into the result register, which waits while an earlier result is not taken. One item
// per cycle while results are taken; the table and its counters update as each result
// is captured, so each item sees every earlier item's reservation without any forwarding.
// Reset (rst_n low, asynchronous): every unit free, all counts zero, no item held,
// unit counts zero and all latencies one.
// ----------------------------------------------------------------------------
// Functional unit reservation
// Issue-stage reservation of pipelined functional units with per-class statistics.
// ----------------------------------------------------------------------------
module functional_unit_reservation
    import fur_pkg::*;
#(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF,
    parameter int UNITS_MAX   = UNITS_MAX_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Configuration write port, no read-back.
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    // Request stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // From bit 0: unit_class[2:0], now_cycle[34:3], first_try_cycle[66:35], zero fill.
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // kind: 0 reserve, 1 release all units.
    input  logic                  s_axis_tuser,

    // Result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // From bit 0: latency[7:0], try_cycle_out[39:8], class_accesses[71:40],
    // class_denials[103:72], class_wait_total[135:104].
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    cfg_t cfg_reg;
    logic in_valid_reg;
    req_t in_req_reg;
    logic out_valid_reg;
    rsp_t out_rsp_reg;
    rsp_t rsp;
    logic in_accept;
    logic fire;

    // The configuration registers are to be written only while the block is idle, so
    // no item in flight ever sees a change half way through; the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.units_per_class     <= UNITS_RESET;
            cfg_reg.issue_latencies     <= LAT_RESET;
            cfg_reg.operation_latencies <= LAT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_UNITS:     cfg_reg.units_per_class     <= cfg_wdata[UNITS_REG_W-1:0];
                CFG_ISSUE_LAT: cfg_reg.issue_latencies     <= cfg_wdata[LAT_REG_W-1:0];
                CFG_OP_LAT:    cfg_reg.operation_latencies <= cfg_wdata[LAT_REG_W-1:0];
                default:       ;
            endcase
        end
    end

    // The item in the input register is processed whenever the result register
    // is empty or is being emptied in the same cycle. The input side stays open
    // as long as the held item moves on, so a waiting result stalls only one item.
    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset; their valid flags guard them.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_req_reg.kind            <= kind_t'(s_axis_tuser);
            in_req_reg.unit_class      <= s_axis_tdata[CLASS_W-1:0];
            in_req_reg.now_cycle       <= s_axis_tdata[CLASS_W +: CYCLE_W];
            in_req_reg.first_try_cycle <= s_axis_tdata[CLASS_W + CYCLE_W +: CYCLE_W];
        end
        if (fire)
        begin
            out_rsp_reg <= rsp;
        end
    end

    // The reservation table works on the held item and commits its update on
    // the same edge that captures the result.
    fur_table #(
        .NUM_CLASSES (NUM_CLASSES),
        .UNITS_MAX   (UNITS_MAX)
    ) u_fur_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_fire (fire),
        .req      (in_req_reg),
        .cfg      (cfg_reg),
        .rsp      (rsp)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({out_rsp_reg.class_wait_total,
                                        out_rsp_reg.class_denials,
                                        out_rsp_reg.class_accesses,
                                        out_rsp_reg.try_cycle_out,
                                        out_rsp_reg.latency});

endmodule

/* src/fur_checker.sv */
// ----------------------------------------------------------------------------
// Functional unit reservation checker
// Port-level checks on flow control and result delivery, bound to the top.
// ----------------------------------------------------------------------------
`include "functional_unit_reservation_defines.svh"

module fur_checker
    import fur_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // A stalled result must hold its value.
    `FUR_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // The input side may only close when a result is waiting and not taken.
    `FUR_ASSERT_IMPL(a_ready_only_on_stall, clk, rst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input closed without an output stall")

    // Once an accepted item could have reached the result register, a result is on offer,
    // either that item's own or an older one that is still waiting to be taken.
    `FUR_ASSERT_IMPL(a_delivery, clk, rst_n, s_axis_tvalid && s_axis_tready, ##2 m_axis_tvalid, "accepted item not delivered in time")

    // No result is presented straight out of reset.
    `FUR_ASSERT_IMPL(a_reset_empty, clk, rst_n, $rose(rst_n), !m_axis_tvalid, "result valid straight after reset")

endmodule

bind functional_unit_reservation fur_checker u_fur_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/functional_unit_reservation_tb.sv */
// ----------------------------------------------------------------------------
// Functional unit reservation: self-checking testbench
// Drives reserve and release requests into the block, predicts each result
// from a behavioural copy of the unit table and its statistics, and compares
// every returned item field by field. Both stream sides idle at random, and
// the result side is held off for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module functional_unit_reservation_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fur_pkg::*;

    localparam int NUM_CLS    = NUM_CLASSES_DEF;
    localparam int UNITS      = UNITS_MAX_DEF;
    localparam int LONG_HOLD  = 80;
    localparam int PHASE_SIZE = 190;

    // A denied request waiting to be retried, with the cycle of its first attempt.
    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic [CYCLE_W-1:0] tryc;
    } retry_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // unit_class, now_cycle, first_try_cycle, zero fill
    logic                  s_axis_tuser;   // kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // latency, try_cycle_out, accesses, denials, wait

    functional_unit_reservation DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Behavioural copy of the block's configuration and state.
    logic [UNITS_REG_W-1:0] units_setting;
    logic [LAT_REG_W-1:0]   issue_setting;
    logic [LAT_REG_W-1:0]   op_setting;
    logic [CYCLE_W-1:0]     unit_busy_until [NUM_CLS*UNITS];
    logic [CNT_W-1:0]       grant_tally     [NUM_CLS];
    logic [CNT_W-1:0]       denial_tally    [NUM_CLS];
    logic [CNT_W-1:0]       wait_tally      [NUM_CLS];

    rsp_t   awaited_results [$];
    retry_t retry_pool      [$];

    logic [CYCLE_W-1:0] cpu_cycle;
    bit src_steady;
    bit sink_steady;
    int hold_off_cycles;
    int failures;
    int n_requests;
    int n_grants;
    int n_denials;
    int n_releases;
    int n_settings;

    // Idle lengths are mostly drawn from the shortest of three ranges, a few from a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom_range(1, 2);
        else if (r < 9)
            return $urandom_range(3, 6);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [CNT_W-1:0] saturating_sum(input logic [CNT_W-1:0] a,
                                                        input logic [CNT_W-1:0] b);
        logic [CNT_W:0] wide;
        wide = {1'b0, a} + {1'b0, b};
        return wide[CNT_W] ? {CNT_W{1'b1}} : wide[CNT_W-1:0];
    endfunction

    // Applies one request to the table copy and returns the result it should give.
    function automatic rsp_t predict_reservation(input kind_t k,
                                                 input logic [CLASS_W-1:0] cls,
                                                 input logic [CYCLE_W-1:0] now,
                                                 input logic [CYCLE_W-1:0] first);
        rsp_t               r;
        retry_t             denied;
        logic [CYCLE_W-1:0] tryc;
        int                 n;
        int                 u;
        int                 slot;
        bit                 granted;
        r = '0;
        n_requests++;
        if (k == KIND_RELEASE)
        begin
            foreach (unit_busy_until[i])
                unit_busy_until[i] = '0;
            n_releases++;
        end
        else if (cls == '0)
        begin
            // No unit needed: never denied, and the attempt cycle passes through.
            r.latency       = 8'd1;
            r.try_cycle_out = first;
        end
        else
        begin
            tryc            = (first == '0) ? now : first;
            r.try_cycle_out = tryc;
            if (cls < NUM_CLS)
            begin
                n = int'(units_setting[UCNT_W*cls +: UCNT_W]);
                if (n > UNITS)
                    n = UNITS;
                granted = 1'b0;
                for (u = 0; u < n && !granted; u++)
                begin
                    slot = cls * UNITS + u;
                    if (unit_busy_until[slot] <= now)
                    begin
                        unit_busy_until[slot] = now + issue_setting[LAT_W*cls +: LAT_W];
                        grant_tally[cls] = saturating_sum(grant_tally[cls], 1);
                        wait_tally[cls]  = saturating_sum(wait_tally[cls], now - tryc);
                        r.latency        = op_setting[LAT_W*cls +: LAT_W];
                        granted          = 1'b1;
                    end
                end
                if (granted)
                begin
                    n_grants++;
                end
                else
                begin
                    denial_tally[cls] = saturating_sum(denial_tally[cls], 1);
                    n_denials++;
                    denied.cls  = cls;
                    denied.tryc = tryc;
                    if (retry_pool.size() < 16)
                        retry_pool.push_back(denied);
                end
            end
        end
        if (cls < NUM_CLS)
        begin
            r.class_accesses   = grant_tally[cls];
            r.class_denials    = denial_tally[cls];
            r.class_wait_total = wait_tally[cls];
        end
        return r;
    endfunction

    task automatic report_failure(input string msg);
        if (failures < 40)
            $display("[%0t] MISMATCH %s", $time, msg);
        failures++;
    endtask

    // Offers one item, starting at a falling edge, and returns at the falling
    // edge after it was taken. Valid is left high so back-to-back items need
    // no extra drive; a gap lowers it first.
    task automatic send_request(input kind_t k, input logic [CLASS_W-1:0] cls,
                                input logic [CYCLE_W-1:0] now,
                                input logic [CYCLE_W-1:0] first);
        int gap;
        gap = 0;
        if (!src_steady && $urandom_range(0, 1) == 0)
            gap = idle_length();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= k;
        s_axis_tdata  <= {{(IN_DATA_W-IN_FIELDS_W){1'b0}}, first, now, cls};
        do
            @(posedge clk);
        while (!s_axis_tready);
        awaited_results.push_back(predict_reservation(k, cls, now, first));
        @(negedge clk);
    endtask

    // Stops offering and waits until every result has come back.
    task automatic finish_phase();
        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Writes all three registers while the block is idle. Junk above the
    // unit-count field must be ignored.
    task automatic load_settings(input logic [UNITS_REG_W-1:0] units,
                                 input logic [LAT_REG_W-1:0] issue,
                                 input logic [LAT_REG_W-1:0] op);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_UNITS;
        cfg_wdata <= {$urandom, 8'($urandom), units};
        @(negedge clk);
        cfg_addr  <= CFG_ISSUE_LAT;
        cfg_wdata <= issue;
        @(negedge clk);
        cfg_addr  <= CFG_OP_LAT;
        cfg_wdata <= op;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
        units_setting = units;
        issue_setting = issue;
        op_setting    = op;
        n_settings++;
    endtask

    // One request of issue-stage traffic: mostly first attempts and retries of
    // denied operations at a slowly advancing cycle, with some releases,
    // class-none requests and arbitrary noise.
    task automatic issue_traffic_item();
        retry_t again;
        int     pick;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 99) == 0)
            cpu_cycle = $urandom;
        else
            cpu_cycle = cpu_cycle + $urandom_range(0, 2);
        if (pick < 4)
        begin
            send_request(KIND_RELEASE, 3'($urandom_range(0, 7)), $urandom, $urandom);
        end
        else if (pick < 10)
        begin
            send_request(KIND_RESERVE, '0, cpu_cycle, $urandom);
        end
        else if (pick < 40 && retry_pool.size() != 0)
        begin
            again = retry_pool.pop_front();
            send_request(KIND_RESERVE, again.cls, cpu_cycle, again.tryc);
        end
        else if (pick < 92)
        begin
            send_request(KIND_RESERVE, 3'($urandom_range(1, 7)), cpu_cycle, '0);
        end
        else
        begin
            send_request(kind_t'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                         $urandom, $urandom);
        end
    endtask

    // Reset settings: no class has any unit, so every real reserve is denied.
    task automatic test_reset_defaults();
        send_request(KIND_RESERVE, 3'd3, 32'd5, '0);
        send_request(KIND_RESERVE, 3'd0, 32'd6, 32'd2);
        send_request(KIND_RELEASE, 3'd3, 32'd7, 32'd1);
        send_request(KIND_RESERVE, 3'd1, 32'd8, 32'd4);
        finish_phase();
    endtask

    task automatic test_directed_cases();
        // Units: class 1 one, class 2 four, class 3 seven (held to the maximum),
        // class 4 none, class 5 two, class 6 three, class 7 five.
        load_settings({3'd5, 3'd3, 3'd2, 3'd0, 3'd7, 3'd4, 3'd1, 3'd0},
                      {8'd2, 8'd4, 8'd255, 8'd1, 8'd0, 8'd5, 8'd3, 8'd0},
                      {8'd9, 8'd6, 8'd3, 8'd1, 8'd7, 8'd255, 8'd0, 8'd0});
        send_request(KIND_RELEASE, 3'd0, '0, '0);
        send_request(KIND_RESERVE, 3'd0, 32'd0, 32'hFFFF_FFFF);
        // Single unit with a zero operation latency: a grant that answers zero,
        // then a denial while busy, then a retry once the unit is free.
        send_request(KIND_RESERVE, 3'd1, 32'd100, '0);
        send_request(KIND_RESERVE, 3'd1, 32'd101, '0);
        send_request(KIND_RESERVE, 3'd1, 32'd103, 32'd101);
        // Four units taken at the same cycle number, the fifth request is turned away.
        repeat (5)
            send_request(KIND_RESERVE, 3'd2, 32'd200, '0);
        // Zero issue latency frees the unit in the same cycle.
        send_request(KIND_RESERVE, 3'd3, 32'd300, '0);
        send_request(KIND_RESERVE, 3'd3, 32'd300, '0);
        send_request(KIND_RESERVE, 3'd4, 32'd400, '0);
        // Busy time wraps past the top of the cycle range.
        send_request(KIND_RESERVE, 3'd5, 32'hFFFF_FFF0, '0);
        send_request(KIND_RESERVE, 3'd5, 32'hFFFF_FFF1, '0);
        // Waiting time that wraps, then one large enough to saturate the sum.
        send_request(KIND_RESERVE, 3'd6, 32'd10, 32'd20);
        send_request(KIND_RESERVE, 3'd6, 32'hFFFF_FFFF, 32'd1);
        send_request(KIND_RESERVE, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(KIND_RELEASE, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(KIND_RESERVE, 3'd2, 32'd200, '0);
        send_request(KIND_RESERVE, 3'd0, '0, '0);
        finish_phase();
    endtask

    // The result side stops for a long stretch while items keep coming, so the
    // block fills and has to hold its input.
    task automatic test_output_backpressure();
        src_steady      = 1'b1;
        hold_off_cycles = LONG_HOLD;
        repeat (48)
            issue_traffic_item();
        src_steady = 1'b0;
        finish_phase();
    endtask

    task automatic test_random_traffic();
        logic [UNITS_REG_W-1:0] units;
        logic [LAT_REG_W-1:0]   issue;
        int                     phase;
        int                     n;
        int                     c;
        for (phase = 0; phase < 5; phase++)
        begin
            for (c = 0; c < PACKED_CLASSES; c++)
            begin
                units[UCNT_W*c +: UCNT_W] = UCNT_W'($urandom_range(0, 7));
                issue[LAT_W*c +: LAT_W]   = ($urandom_range(0, 9) == 0) ? 8'd255
                                            : LAT_W'($urandom_range(0, 10));
            end
            case (phase)
                1: load_settings('1, '1, '0);
                2: load_settings(units, '0, '1);
                default: load_settings(units, issue, {$urandom, $urandom});
            endcase
            if (phase == 4)
                cpu_cycle = 32'hFFFF_FF00;
            for (n = 0; n < PHASE_SIZE; n++)
            begin
                if (n % 64 == 0)
                begin
                    src_steady  = ($urandom_range(0, 3) == 0);
                    sink_steady = ($urandom_range(0, 3) == 0);
                end
                issue_traffic_item();
            end
            src_steady  = 1'b0;
            sink_steady = 1'b0;
            finish_phase();
        end
    endtask

    // Result side: random stalls, occasional stall-free stretches, and the
    // long hold-off when one is asked for.
    initial
    begin : result_sink
        int stall;
        stall         = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_off_cycles--;
            end
            else if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!sink_steady && $urandom_range(0, 3) == 0)
                    stall = idle_length();
            end
        end
    end

    // Every accepted result is matched against the oldest prediction.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (awaited_results.size() == 0)
            begin
                report_failure($sformatf("result with nothing outstanding, data %h",
                                         m_axis_tdata));
            end
            else
            begin
                want = awaited_results.pop_front();
                if (m_axis_tdata[7:0] !== want.latency)
                    report_failure($sformatf("latency got %0d want %0d",
                                             m_axis_tdata[7:0], want.latency));
                if (m_axis_tdata[39:8] !== want.try_cycle_out)
                    report_failure($sformatf("try_cycle_out got %h want %h",
                                             m_axis_tdata[39:8], want.try_cycle_out));
                if (m_axis_tdata[71:40] !== want.class_accesses)
                    report_failure($sformatf("class_accesses got %0d want %0d",
                                             m_axis_tdata[71:40], want.class_accesses));
                if (m_axis_tdata[103:72] !== want.class_denials)
                    report_failure($sformatf("class_denials got %0d want %0d",
                                             m_axis_tdata[103:72], want.class_denials));
                if (m_axis_tdata[135:104] !== want.class_wait_total)
                    report_failure($sformatf("class_wait_total got %h want %h",
                                             m_axis_tdata[135:104], want.class_wait_total));
            end
        end
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("Run did not complete in the time allowed.");
        $display("status: fail");
        $finish;
    end

    initial
    begin : main_sequence
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_addr        = CFG_UNITS;
        cfg_wdata       = '0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = KIND_RESERVE;
        src_steady      = 1'b0;
        sink_steady     = 1'b0;
        hold_off_cycles = 0;
        failures        = 0;
        n_requests      = 0;
        n_grants        = 0;
        n_denials       = 0;
        n_releases      = 0;
        n_settings      = 0;
        cpu_cycle       = 32'd1000;
        units_setting   = UNITS_RESET;
        issue_setting   = LAT_RESET;
        op_setting      = LAT_RESET;
        foreach (unit_busy_until[i])
            unit_busy_until[i] = '0;
        foreach (grant_tally[i])
        begin
            grant_tally[i]  = '0;
            denial_tally[i] = '0;
            wait_tally[i]   = '0;
        end

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_directed_cases();
        test_output_backpressure();
        test_random_traffic();

        // Any stray result in this window is reported by the result comparison.
        repeat (10) @(negedge clk);

        $display("Checked %0d requests: %0d grants, %0d denials, %0d releases.",
                 n_requests, n_grants, n_denials, n_releases);
        $display("Used %0d register settings and one result stall of %0d cycles.",
                 n_settings, LONG_HOLD);
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/fur_pkg.sv
src/fur_table.sv
src/functional_unit_reservation.sv
src/fur_checker.sv
tb/functional_unit_reservation_tb.sv
